@@ rtl/flow_table_packet_counter_assert.svh @@
// Assertion macros shared by the flow table RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef FLOW_TABLE_PACKET_COUNTER_ASSERT_SVH
`define FLOW_TABLE_PACKET_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ftpc_pkg.sv @@
// Shared types and constants of the flow table packet counter.
// No dependencies; used by the top level.
package ftpc_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SCAN_W        = $clog2(TABLE_ENTRIES + 1);

  // Field widths.
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int CNT_W   = 32;
  localparam int SLOT_W  = 7;

  localparam logic [PORT_W-1:0] LISTEN_PORT_RESET = 16'd9090;
  localparam logic              MODE_CLOSE        = 1'b1;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [CNT_W-1:0]  count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_COUNTED  = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_FULL     = 3'd3,
    ST_FILTERED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_SCAN,
    FS_UPDATE,
    FS_DONE
  } fsm_state_t;

  // Low bits of a table index as reported in the slot field.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext     = {{SLOT_W{1'b0}}, idx};
    to_slot = ext[SLOT_W-1:0];
  endfunction

endpackage

@@ rtl/ftpc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ftpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/flow_table_packet_counter.sv @@
// Top level of the flow table packet counter: control, scan and result register.
// Depends on ftpc_pkg, ftpc_ram and flow_table_packet_counter_assert.svh.
//
//  channel | handshake         | payload
//  --------+-------------------+---------------------------------------------
//  in      | in_valid/in_stall | mode, is_udp, src_addr, src_port, dst_port
//  out     | out_valid/stall   | status, slot, packet_count
//  cfg     | cfg_valid/ready   | listen_port
//
// A filtered packet skips the scan; any other goes through the scan, which reads one table
// entry per cycle, and then through the table update.
// After reset a clearing pass writes zero to every entry while in_stall stays high;
// configuration writes are taken throughout.
// A waiting result sits in the output register while the next packet is scanned;
// its transaction completes only when out_stall is low.
module flow_table_packet_counter import ftpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Packet input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic              in_is_udp,
  input  logic [ADDR_W-1:0] in_src_addr,
  input  logic [PORT_W-1:0] in_src_port,
  input  logic [PORT_W-1:0] in_dst_port,
  // Result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [SLOT_W-1:0] out_slot,
  output logic [CNT_W-1:0]  out_packet_count,
  // Configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PORT_W-1:0] cfg_listen_port
);

  fsm_state_t state_r, state_nxt;

  logic [PORT_W-1:0] listen_port_r;

  // Packet held for the duration of its scan.
  logic              pkt_mode_r;
  logic [ADDR_W-1:0] pkt_addr_r;
  logic [PORT_W-1:0] pkt_port_r;

  // Scan and tracking state.
  logic [IDX_W-1:0]  clr_idx_r;
  logic [SCAN_W-1:0] scan_cnt_r;
  logic              chk_vld_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic              hit_found_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [CNT_W-1:0]  hit_cnt_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;

  // Pending result and output register.
  status_t           res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [CNT_W-1:0]  res_count_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [CNT_W-1:0]  out_count_r;

  // Memory ports.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wentry;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;

  logic              in_accept;
  logic              pkt_filtered;
  logic              pkt_close;
  logic              chk_last;
  logic              scan_done;
  logic              out_counted;
  logic              rd_match;
  logic              rd_free;
  logic              res_load;
  status_t           upd_status;
  logic [SLOT_W-1:0] upd_slot;
  logic [CNT_W-1:0]  upd_count;
  logic [CNT_W-1:0]  sat_count;

  ftpc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wentry),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Handshake terms.
  assign in_stall     = (state_r != FS_IDLE);
  assign in_accept    = in_valid && !in_stall;
  assign pkt_filtered = !in_is_udp || (in_dst_port != listen_port_r);
  assign pkt_close    = (pkt_mode_r == MODE_CLOSE);
  assign cfg_ready    = 1'b1;
  assign res_load     = (state_r == FS_DONE) && (!out_valid_r || !out_stall);

  // Scan read side: one address per cycle until every entry is issued.
  assign ram_re    = (state_r == FS_SCAN) && (scan_cnt_r != SCAN_W'(TABLE_ENTRIES));
  assign ram_raddr = scan_cnt_r[IDX_W-1:0];
  assign chk_last  = (chk_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign scan_done = (state_r == FS_SCAN) && chk_vld_r && chk_last;
  assign rd_match  = (rd_entry.addr == pkt_addr_r) && (rd_entry.port == pkt_port_r);
  assign rd_free   = (rd_entry.addr == '0) && (rd_entry.port == '0);

  assign sat_count = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + CNT_W'(1);

  // Clearing writes, and write-back decision and result of a scanned packet.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = clr_idx_r;
    ram_wentry = '0;
    upd_status = ST_FULL;
    upd_slot   = '0;
    upd_count  = '0;
    if (state_r == FS_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_r == FS_UPDATE) begin
      if (pkt_close) begin
        if (hit_found_r) begin
          ram_we     = 1'b1;
          ram_waddr  = hit_idx_r;
          upd_status = ST_REMOVED;
          upd_slot   = to_slot(hit_idx_r);
        end else begin
          upd_status = ST_UNKNOWN;
        end
      end else if (hit_found_r) begin
        ram_we           = 1'b1;
        ram_waddr        = hit_idx_r;
        ram_wentry.addr  = pkt_addr_r;
        ram_wentry.port  = pkt_port_r;
        ram_wentry.count = sat_count;
        upd_status       = ST_COUNTED;
        upd_slot         = to_slot(hit_idx_r);
        upd_count        = sat_count;
      end else if (free_found_r) begin
        ram_we           = 1'b1;
        ram_waddr        = free_idx_r;
        ram_wentry.addr  = pkt_addr_r;
        ram_wentry.port  = pkt_port_r;
        ram_wentry.count = CNT_W'(1);
        upd_status       = ST_COUNTED;
        upd_slot         = to_slot(free_idx_r);
        upd_count        = CNT_W'(1);
      end else begin
        upd_status = ST_FULL;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_CLEAR: begin
        if (clr_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = FS_IDLE;
        end
      end
      FS_IDLE: begin
        if (in_accept) begin
          state_nxt = pkt_filtered ? FS_DONE : FS_SCAN;
        end
      end
      FS_SCAN: begin
        if (scan_done) begin
          state_nxt = FS_UPDATE;
        end
      end
      FS_UPDATE: begin
        state_nxt = FS_DONE;
      end
      FS_DONE: begin
        if (res_load) begin
          state_nxt = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Listening port register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_port_r <= LISTEN_PORT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      listen_port_r <= cfg_listen_port;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (state_r == FS_CLEAR) begin
      clr_idx_r <= clr_idx_r + IDX_W'(1);
    end
  end

  // Packet capture, scan tracking and pending result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r   <= '0;
      chk_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (in_accept) begin
        pkt_mode_r   <= in_mode;
        pkt_addr_r   <= in_src_addr;
        pkt_port_r   <= in_src_port;
        scan_cnt_r   <= '0;
        chk_vld_r    <= 1'b0;
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
        res_status_r <= ST_FILTERED;
        res_slot_r   <= '0;
        res_count_r  <= '0;
      end
      if (state_r == FS_SCAN) begin
        chk_vld_r <= ram_re;
        chk_idx_r <= ram_raddr;
        if (ram_re) begin
          scan_cnt_r <= scan_cnt_r + SCAN_W'(1);
        end
        if (chk_vld_r && !hit_found_r && rd_match) begin
          hit_found_r <= 1'b1;
          hit_idx_r   <= chk_idx_r;
          hit_cnt_r   <= rd_entry.count;
        end
        if (chk_vld_r && !free_found_r && rd_free) begin
          free_found_r <= 1'b1;
          free_idx_r   <= chk_idx_r;
        end
      end
      if (state_r == FS_UPDATE) begin
        res_status_r <= upd_status;
        res_slot_r   <= upd_slot;
        res_count_r  <= upd_count;
      end
    end
  end

  // Output register: holds a result until its transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_count_r  <= res_count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_packet_count = out_count_r;

  // A valid result that reports a counted packet.
  assign out_counted = out_valid_r && (out_status_r == ST_COUNTED);

  `include "flow_table_packet_counter_assert.svh"

  // The table is never written while a scan reads it.
  `FTPC_ASSERT_SAME(a_no_write_in_scan, state_r == FS_SCAN, !ram_we, "table write during scan")
  // A pending result never overwrites one that is still waiting.
  `FTPC_ASSERT_SAME(a_no_overwrite, res_load, !out_valid_r || !out_stall, "result overwritten")
  // A counted result carries a nonzero count; every other result carries zero.
  `FTPC_ASSERT_SAME(a_count_zero, out_valid_r && !out_counted, out_count_r == '0, "stray count")
  `FTPC_ASSERT_SAME(a_count_nonzero, out_counted, out_count_r != '0, "missing count")
  // The last entry checked ends the scan.
  `FTPC_ASSERT_NEXT(a_scan_end, scan_done, state_r == FS_UPDATE, "scan did not end")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for flow_table_packet_counter: directed packets, then random flows.
// Depends on ftpc_pkg and the flow_table_packet_counter RTL; an internal flow table predicts
// every result not given in a directed row, and each result is compared field by field in arrival order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ftpc_pkg::*;

  localparam logic MODE_MSG    = ~MODE_CLOSE;
  localparam int   MAX_GAP     = 18;
  localparam int   END_WAIT    = TABLE_ENTRIES + 12;
  localparam int   CYCLE_LIMIT = 600000;
  localparam int   POOL_MAX    = 256;

  typedef struct {
    logic              mode;
    logic              is_udp;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
  } packet_t;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } verdict_t;

  typedef struct {
    packet_t  pkt;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_mode;
  logic              in_is_udp;
  logic [ADDR_W-1:0] in_src_addr;
  logic [PORT_W-1:0] in_src_port;
  logic [PORT_W-1:0] in_dst_port;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [CNT_W-1:0]  out_packet_count;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [PORT_W-1:0] cfg_listen_port;

  // Predicted flow table and listening port, all free after reset.
  logic [ADDR_W-1:0] flow_addr_q [TABLE_ENTRIES];
  logic [PORT_W-1:0] flow_port_q [TABLE_ENTRIES];
  logic [CNT_W-1:0]  flow_count_q [TABLE_ENTRIES];
  logic [PORT_W-1:0] listen_q = LISTEN_PORT_RESET;

  verdict_t          pending_verdicts [$];
  dir_row_t          dir_rows [$];
  logic [ADDR_W-1:0] pool_addr [POOL_MAX];
  logic [PORT_W-1:0] pool_port [POOL_MAX];
  int                pool_n;
  int                mismatches = 0;
  int                cycles = 0;
  int                sends = 0;
  int                recvs = 0;
  bit                drv_quiet = 1'b0;
  bit                rcv_quiet = 1'b0;

  flow_table_packet_counter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_is_udp        (in_is_udp),
    .in_src_addr      (in_src_addr),
    .in_src_port      (in_src_port),
    .in_dst_port      (in_dst_port),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_packet_count (out_packet_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_listen_port  (cfg_listen_port)
  );

  always #2 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Applies one packet to the predicted table and returns the result it should produce.
  function automatic verdict_t count_packet(packet_t p);
    verdict_t v;
    int       hit;
    int       free_idx;
    hit      = -1;
    free_idx = -1;
    v.status = ST_FILTERED;
    v.slot   = '0;
    v.count  = '0;
    if (!p.is_udp || p.dport != listen_q) return v;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && flow_addr_q[i] == p.addr && flow_port_q[i] == p.sport) hit = i;
      if (free_idx < 0 && flow_addr_q[i] == '0 && flow_port_q[i] == '0) free_idx = i;
    end
    if (p.mode == MODE_CLOSE) begin
      if (hit < 0) begin
        v.status = ST_UNKNOWN;
      end else begin
        flow_addr_q[hit]  = '0;
        flow_port_q[hit]  = '0;
        flow_count_q[hit] = '0;
        v.status = ST_REMOVED;
        v.slot   = hit[SLOT_W-1:0];
      end
      return v;
    end
    // A new flow takes the lowest free slot with its counter restarted.
    if (hit < 0) begin
      if (free_idx < 0) begin
        v.status = ST_FULL;
        return v;
      end
      hit = free_idx;
      flow_addr_q[hit]  = p.addr;
      flow_port_q[hit]  = p.sport;
      flow_count_q[hit] = '0;
    end
    if (flow_count_q[hit] != '1) flow_count_q[hit] = flow_count_q[hit] + 1'b1;
    v.status = ST_COUNTED;
    v.slot   = hit[SLOT_W-1:0];
    v.count  = flow_count_q[hit];
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    $display("tb_top: mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // Sends one packet transaction and queues its expected result on acceptance.
  task automatic send_packet(packet_t p, bit typed, verdict_t want);
    int       gap;
    verdict_t v;
    if (sends % 16 == 0) drv_quiet = ($urandom_range(0, 3) == 0);
    sends++;
    gap = drv_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= p.mode;
    in_is_udp   <= p.is_udp;
    in_src_addr <= p.addr;
    in_src_port <= p.sport;
    in_dst_port <= p.dport;
    do @(posedge clk); while (in_stall);
    v = count_packet(p);
    pending_verdicts.push_back(typed ? want : v);
  endtask

  task automatic send_checked(packet_t p);
    verdict_t none;
    none = '{ST_COUNTED, '0, '0};
    send_packet(p, 1'b0, none);
  endtask

  // Stops the input side and waits until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_listen(logic [PORT_W-1:0] val);
    cfg_valid       <= 1'b1;
    cfg_listen_port <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    listen_q   = val;
  endtask

  task automatic fill_pool(int n, bit with_zero);
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      pool_addr[i] = $urandom;
      pool_port[i] = PORT_W'($urandom_range(0, 65535));
    end
    if (with_zero) begin
      pool_addr[0] = '0;
      pool_port[0] = '0;
    end
  endtask

  // Mostly accepted packets from the current flow pool; some filtered and some pure noise.
  function automatic packet_t make_packet();
    packet_t p;
    int      r;
    int      k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, pool_n - 1);
    p.addr   = pool_addr[k];
    p.sport  = pool_port[k];
    p.dport  = listen_q;
    p.is_udp = 1'b1;
    p.mode   = ($urandom_range(0, 4) == 0) ? MODE_CLOSE : MODE_MSG;
    if (r < 10) begin
      p.mode   = 1'($urandom_range(0, 1));
      p.is_udp = 1'($urandom_range(0, 1));
      p.addr   = $urandom;
      p.sport  = PORT_W'($urandom_range(0, 65535));
      p.dport  = PORT_W'($urandom_range(0, 65535));
    end else if (r < 16) begin
      p.is_udp = 1'b0;
    end else if (r < 20) begin
      p.dport = listen_q ^ (16'd1 << $urandom_range(0, 15));
    end
    return p;
  endfunction

  task automatic add_row(logic mode, logic udp, logic [ADDR_W-1:0] addr,
                         logic [PORT_W-1:0] sport, logic [PORT_W-1:0] dport, bit typed,
                         status_t st, logic [SLOT_W-1:0] slot, logic [CNT_W-1:0] cnt);
    dir_row_t row;
    row.pkt   = '{mode, udp, addr, sport, dport};
    row.typed = typed;
    row.want  = '{st, slot, cnt};
    dir_rows.push_back(row);
  endtask

  // Result side: random stall per transaction, then field-by-field comparison.
  initial begin
    int       w;
    verdict_t v;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (recvs % 16 == 0) rcv_quiet = ($urandom_range(0, 3) == 0);
      recvs++;
      w = rcv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result, status", CNT_W'(out_status), '0);
      end else begin
        v = pending_verdicts.pop_front();
        if (out_status !== v.status) begin
          report_mismatch("status", CNT_W'(out_status), CNT_W'(v.status));
        end
        if (out_slot !== v.slot) begin
          report_mismatch("slot", CNT_W'(out_slot), CNT_W'(v.slot));
        end
        if (out_packet_count !== v.count) begin
          report_mismatch("packet_count", out_packet_count, v.count);
        end
      end
    end
  end

  // Stimulus: directed rows at the reset port, then random phases at other ports.
  initial begin
    localparam logic [PORT_W-1:0] LP = LISTEN_PORT_RESET;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      flow_addr_q[i]  = '0;
      flow_port_q[i]  = '0;
      flow_count_q[i] = '0;
    end
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = 1'b0;
    in_is_udp       = 1'b0;
    in_src_addr     = '0;
    in_src_port     = '0;
    in_dst_port     = '0;
    cfg_valid       = 1'b0;
    cfg_listen_port = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Filtering, unknown close, address and port extremes, and the all-zero flow.
    add_row(MODE_MSG, 1'b0, 32'h0A00_0001, 16'd1234, LP, 1, ST_FILTERED, 0, 0);
    add_row(MODE_MSG, 1'b1, 32'h0A00_0001, 16'd1234, LP + 1'b1, 1, ST_FILTERED, 0, 0);
    add_row(MODE_CLOSE, 1'b0, 32'h0A00_0001, 16'd1234, LP, 1, ST_FILTERED, 0, 0);
    add_row(MODE_CLOSE, 1'b1, 32'h0A00_0001, 16'd1234, LP, 1, ST_UNKNOWN, 0, 0);
    add_row(MODE_MSG, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, LP, 1, ST_COUNTED, 0, 1);
    add_row(MODE_MSG, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, LP, 1, ST_COUNTED, 0, 2);
    add_row(MODE_MSG, 1'b1, 32'h0000_0001, 16'h0000, LP, 1, ST_COUNTED, 1, 1);
    // The zero flow matches the first free slot, which stays free.
    add_row(MODE_MSG, 1'b1, 32'h0, 16'h0, LP, 1, ST_COUNTED, 2, 1);
    add_row(MODE_MSG, 1'b1, 32'h0, 16'h0, LP, 1, ST_COUNTED, 2, 2);
    add_row(MODE_MSG, 1'b1, 32'h0, 16'h0001, LP, 1, ST_COUNTED, 2, 1);
    add_row(MODE_MSG, 1'b1, 32'h0, 16'h0, LP, 1, ST_COUNTED, 3, 1);
    add_row(MODE_CLOSE, 1'b1, 32'h0, 16'h0, LP, 1, ST_REMOVED, 3, 0);
    add_row(MODE_CLOSE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, LP, 1, ST_REMOVED, 0, 0);
    add_row(MODE_MSG, 1'b1, 32'h8000_0000, 16'h8000, LP, 1, ST_COUNTED, 0, 1);
    add_row(MODE_CLOSE, 1'b1, 32'h0000_0001, 16'h0000, LP, 1, ST_REMOVED, 1, 0);
    add_row(MODE_CLOSE, 1'b1, 32'h0000_0001, 16'h0000, LP, 1, ST_UNKNOWN, 0, 0);
    add_row(MODE_MSG, 1'b1, 32'h0A00_0001, 16'd1234, LP, 0, ST_COUNTED, 0, 0);
    add_row(MODE_MSG, 1'b1, 32'h0A00_0001, 16'd1234, LP, 0, ST_COUNTED, 0, 0);
    add_row(MODE_MSG, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1, ST_FILTERED, 0, 0);
    add_row(MODE_MSG, 1'b1, 32'h7FFF_FFFF, 16'h7FFF, 16'hFFFF, 1, ST_FILTERED, 0, 0);
    foreach (dir_rows[i]) send_packet(dir_rows[i].pkt, dir_rows[i].typed, dir_rows[i].want);

    // Lowest listening port, a few flows including the zero flow.
    drain();
    write_listen(16'h0000);
    fill_pool(6, 1);
    repeat (150) send_checked(make_packet());

    // Highest listening port, a wider pool.
    drain();
    write_listen(16'hFFFF);
    fill_pool(12, 0);
    repeat (150) send_checked(make_packet());

    // Random port: open more flows than the table holds, then churn on them.
    drain();
    write_listen(PORT_W'($urandom_range(1, 65534)));
    fill_pool(TABLE_ENTRIES + 8, 0);
    for (int k = 0; k < pool_n; k++) begin
      packet_t p;
      p = '{MODE_MSG, 1'b1, pool_addr[k], pool_port[k], listen_q};
      send_checked(p);
    end
    repeat (100) send_checked(make_packet());

    // Let the last results come back, then allow the block to settle.
    drain();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
